// ===== src/h2r_pkg.sv =====
// Shared widths, constants, sector codes and helper functions of the HSV to RGB converter.
package h2r_pkg;

    localparam int COLOR_BITS = 8;
    localparam int HUE_BITS   = 15;
    localparam int FRAC_BITS  = 12;
    localparam int PROD_BITS  = COLOR_BITS + FRAC_BITS;
    localparam int WIDE_BITS  = 2 * COLOR_BITS + FRAC_BITS;

    localparam logic [COLOR_BITS-1:0] COLOR_MAX  = '1;
    localparam logic [COLOR_BITS-1:0] COLOR_HALF = COLOR_MAX >> 1;
    localparam logic [PROD_BITS-1:0]  FULL_SCALE = {COLOR_MAX, {FRAC_BITS{1'b0}}};
    localparam logic [PROD_BITS-1:0]  HALF_SCALE = FULL_SCALE >> 1;
    localparam logic [FRAC_BITS:0]    FRAC_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

    // 360 degrees and 60 degrees in units of 1/64 degree.
    localparam logic [HUE_BITS-1:0] HUE_FULL   = 15'd23040;
    localparam logic [HUE_BITS-1:0] HUE_SECTOR = 15'd3840;

    // rem * 4096 / 3840 = rem * 16 / 15, done as rem * ceil(2^19 / 15) >> 15.
    // The error term stays below one LSB for every remainder below one sector.
    localparam int                RECIP_BITS = 16;
    localparam logic [RECIP_BITS-1:0] FRAC_RECIP = 16'd34953;
    localparam int                FRAC_SHIFT = 15;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // Floor division by 2^COLOR_BITS - 1, exact for every y below 2^COLOR_BITS * COLOR_MAX.
    function automatic logic [COLOR_BITS-1:0] div_by_max(input logic [2*COLOR_BITS-1:0] y);
        logic [2*COLOR_BITS:0] t;
        t = {1'b0, y} + (2*COLOR_BITS+1)'(y >> COLOR_BITS) + (2*COLOR_BITS+1)'(1);
        return t[COLOR_BITS +: COLOR_BITS];
    endfunction

endpackage

// ===== src/h2r_if.sv =====
// Request channel interfaces of the HSV to RGB converter: HSV pixels in, RGB pixels out.
interface h2r_hsv_if;
    import h2r_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [HUE_BITS-1:0]   hue_in;
    logic [COLOR_BITS-1:0] sat_in;
    logic [COLOR_BITS-1:0] val_in;

    modport source (output valid, output hue_in, output sat_in, output val_in, input ready);
    modport sink   (input valid, input hue_in, input sat_in, input val_in, output ready);
endinterface

interface h2r_rgb_if;
    import h2r_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red_out;
    logic [COLOR_BITS-1:0] green_out;
    logic [COLOR_BITS-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

// ===== src/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: eight-stage pipeline from accepted request to output.
// Throughput is one pixel per clock; the whole pipeline advances together and holds on a stall
// of the output while its last stage is full.
// Multipliers sit in stages 3, 4 and 6; the other stages hold compares, subtracts, adds and routing.
// Reset (synchronous, active low) empties the pipeline by clearing its valid bits; the data registers are not reset.
module hsv_to_rgb_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    h2r_hsv_if.sink       i_hsv,
    h2r_rgb_if.source     o_rgb
);
    import h2r_pkg::*;

    localparam int STAGES = 8;

    logic              adv;
    logic [STAGES-1:0] r_vld;

    // Stage 1: hue wrap.
    logic [HUE_BITS-1:0]   r1_hue, n1_hue;
    logic [COLOR_BITS-1:0] r1_s, r1_v;
    // Stage 2: sector and remainder.
    t_sector               r2_sec, n2_sec;
    logic [FRAC_BITS-1:0]  r2_rem, n2_rem;
    logic [HUE_BITS-1:0]   n2_base;
    logic [HUE_BITS-1:0]   n2_diff;
    logic [COLOR_BITS-1:0] r2_s, r2_v;
    // Stage 3: fraction.
    t_sector               r3_sec;
    logic [FRAC_BITS-1:0]  r3_f;
    logic [FRAC_BITS+RECIP_BITS-1:0] n3_prod;
    logic [COLOR_BITS-1:0] r3_s, r3_v;
    // Stage 4: products with saturation.
    t_sector               r4_sec;
    logic [PROD_BITS-1:0]  r4_sf, r4_sfc;
    logic [FRAC_BITS:0]    n4_fc;
    logic [2*COLOR_BITS-1:0] r4_m1;
    logic [COLOR_BITS-1:0] r4_v;
    // Stage 5: complements against full scale.
    t_sector               r5_sec;
    logic [PROD_BITS-1:0]  r5_t2, r5_t3;
    logic [2*COLOR_BITS-1:0] r5_y1;
    logic [COLOR_BITS-1:0] r5_v;
    // Stage 6: scale by value.
    t_sector               r6_sec;
    logic [WIDE_BITS-1:0]  r6_n2, r6_n3;
    logic [2*COLOR_BITS-1:0] r6_y1;
    logic [COLOR_BITS-1:0] r6_v;
    // Stage 7: rounding divide.
    t_sector               r7_sec;
    logic [COLOR_BITS-1:0] r7_p1, r7_p2, r7_p3, r7_v;
    logic [WIDE_BITS-1:0]  n7_sum2, n7_sum3;
    // Stage 8: routed outputs.
    logic [COLOR_BITS-1:0] r8_red, r8_grn, r8_blu;
    logic [COLOR_BITS-1:0] n8_red, n8_grn, n8_blu;

    // The pipeline moves whenever the output register is free or being drained.
    assign adv         = !r_vld[STAGES-1] || o_rgb.ready;
    assign i_hsv.ready = adv && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_hsv.valid};
        end
    end

    always_comb begin
        n1_hue = (i_hsv.hue_in >= HUE_FULL) ? i_hsv.hue_in - HUE_FULL : i_hsv.hue_in;
    end

    always_comb begin
        if (r1_hue >= HUE_BITS'(5 * HUE_SECTOR)) begin
            n2_sec  = SEC_MAG_RED;
            n2_base = HUE_BITS'(5 * HUE_SECTOR);
        end else if (r1_hue >= HUE_BITS'(4 * HUE_SECTOR)) begin
            n2_sec  = SEC_BLU_MAG;
            n2_base = HUE_BITS'(4 * HUE_SECTOR);
        end else if (r1_hue >= HUE_BITS'(3 * HUE_SECTOR)) begin
            n2_sec  = SEC_CYN_BLU;
            n2_base = HUE_BITS'(3 * HUE_SECTOR);
        end else if (r1_hue >= HUE_BITS'(2 * HUE_SECTOR)) begin
            n2_sec  = SEC_GRN_CYN;
            n2_base = HUE_BITS'(2 * HUE_SECTOR);
        end else if (r1_hue >= HUE_SECTOR) begin
            n2_sec  = SEC_YEL_GRN;
            n2_base = HUE_SECTOR;
        end else begin
            n2_sec  = SEC_RED_YEL;
            n2_base = '0;
        end
        n2_diff = r1_hue - n2_base;
        n2_rem  = n2_diff[FRAC_BITS-1:0];
    end

    assign n3_prod = (FRAC_BITS+RECIP_BITS)'(r2_rem) * (FRAC_BITS+RECIP_BITS)'(FRAC_RECIP);
    assign n4_fc   = FRAC_ONE - {1'b0, r3_f};
    assign n7_sum2 = r6_n2 + WIDE_BITS'(HALF_SCALE);
    assign n7_sum3 = r6_n3 + WIDE_BITS'(HALF_SCALE);

    always_comb begin
        case (r7_sec)
            SEC_RED_YEL: begin n8_red = r7_v;  n8_grn = r7_p3; n8_blu = r7_p1; end
            SEC_YEL_GRN: begin n8_red = r7_p2; n8_grn = r7_v;  n8_blu = r7_p1; end
            SEC_GRN_CYN: begin n8_red = r7_p1; n8_grn = r7_v;  n8_blu = r7_p3; end
            SEC_CYN_BLU: begin n8_red = r7_p1; n8_grn = r7_p2; n8_blu = r7_v;  end
            SEC_BLU_MAG: begin n8_red = r7_p3; n8_grn = r7_p1; n8_blu = r7_v;  end
            default:     begin n8_red = r7_v;  n8_grn = r7_p1; n8_blu = r7_p2; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_hue <= n1_hue;
            r1_s   <= i_hsv.sat_in;
            r1_v   <= i_hsv.val_in;

            r2_sec <= n2_sec;
            r2_rem <= n2_rem;
            r2_s   <= r1_s;
            r2_v   <= r1_v;

            r3_sec <= r2_sec;
            r3_f   <= n3_prod[FRAC_SHIFT +: FRAC_BITS];
            r3_s   <= r2_s;
            r3_v   <= r2_v;

            r4_sec <= r3_sec;
            r4_sf  <= PROD_BITS'(r3_s) * PROD_BITS'(r3_f);
            r4_sfc <= PROD_BITS'(r3_s) * PROD_BITS'(n4_fc);
            r4_m1  <= (2*COLOR_BITS)'(r3_v) * (2*COLOR_BITS)'(COLOR_MAX - r3_s);
            r4_v   <= r3_v;

            r5_sec <= r4_sec;
            r5_t2  <= FULL_SCALE - r4_sf;
            r5_t3  <= FULL_SCALE - r4_sfc;
            r5_y1  <= r4_m1 + (2*COLOR_BITS)'(COLOR_HALF);
            r5_v   <= r4_v;

            r6_sec <= r5_sec;
            r6_n2  <= WIDE_BITS'(r5_v) * WIDE_BITS'(r5_t2);
            r6_n3  <= WIDE_BITS'(r5_v) * WIDE_BITS'(r5_t3);
            r6_y1  <= r5_y1;
            r6_v   <= r5_v;

            r7_sec <= r6_sec;
            r7_p1  <= div_by_max(r6_y1);
            r7_p2  <= div_by_max(n7_sum2[FRAC_BITS +: 2*COLOR_BITS]);
            r7_p3  <= div_by_max(n7_sum3[FRAC_BITS +: 2*COLOR_BITS]);
            r7_v   <= r6_v;

            r8_red <= n8_red;
            r8_grn <= n8_grn;
            r8_blu <= n8_blu;
        end
    end

    assign o_rgb.valid     = r_vld[STAGES-1];
    assign o_rgb.red_out   = r8_red;
    assign o_rgb.green_out = r8_grn;
    assign o_rgb.blue_out  = r8_blu;

endmodule
